### src/assert_macros.svh
// Assertion macros for the RTL files; included by ffa_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent property checked at every rising clock edge outside reset.
`define FFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent check that also holds during reset.
`define FFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFA_ASSERT(label, clk, rst_n, prop, msg)
`define FFA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types, codes and sizes shared by the segment allocator files.
// ----------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
  localparam int MaxSegments = 64;
  localparam int HeaderBytes = 32;
  localparam int OffsetBits  = 32;
  localparam int MinSegment  = HeaderBytes + 16;
  localparam int CntW        = $clog2(MaxSegments + 1);
  localparam int IdxW        = $clog2(MaxSegments);

  localparam logic [1:0] ACT_INIT    = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNINIT  = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_OOM     = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_DOUBLE  = 3'd5;
  localparam logic [2:0] ST_NULL    = 3'd6;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_REGION = 1'b1;

  // Cell operations, applied by every cell in the same cycle.
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_INIT   = 3'd1;
  localparam logic [2:0] OP_SPLIT  = 3'd2; // mark target used, shift up above it
  localparam logic [2:0] OP_MARK   = 3'd3; // mark target used, no split
  localparam logic [2:0] OP_FREE   = 3'd4; // mark target free
  localparam logic [2:0] OP_MERGE  = 3'd5; // grow target by next, shift down above

  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic [OffsetBits-1:0] length;
    logic                  is_free;
  } seg_t;

  typedef struct packed {
    logic [2:0]            op;
    logic [IdxW-1:0]       target;
    logic [OffsetBits-1:0] need;
    logic [OffsetBits-1:0] init_len;
  } cell_ctl_t;
endpackage
`default_nettype wire

### src/ffa_if.sv
// ----------------------------------------------------------------------------
// ffa_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface ffa_stream_if #(parameter int W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit heap segment allocator with coalescing, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage: configure base_address (index 0) and region_bytes (index 1) through
// the cfg port while idle, then send an initialize item. Each input item on
// in_ carries an action; exactly one result item leaves on out_ for each.
// The table lives in a row of 64 cells; a sequencer scans it one entry a
// cycle through a read mux while every cell applies the same shift, split or
// merge operation at once. Release takes the search to the matching entry
// plus a merge pass over the table. One item is worked on at a time. Reset
// clears counts and readiness; cell contents stay undefined until initialize.
// A stalled result holds in the output register and no new item is taken
// until it leaves.
`default_nettype none
module first_fit_segment_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data,
  ffa_stream_if.sink       in_if,
  ffa_stream_if.source     out_if
);
  localparam int N = ffa_pkg::MaxSegments;
  ffa_pkg::seg_t segs [N];
  ffa_pkg::cell_ctl_t ctl;
  logic [ffa_pkg::IdxW-1:0] scan_idx;
  ffa_pkg::seg_t scan_seg, scan_next;

  assign scan_seg  = segs[scan_idx];
  assign scan_next = segs[scan_idx + 1'b1];

  ffa_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_action(in_if.data[81:80]), .in_request_bytes(in_if.data[79:48]),
    .in_release_address(in_if.data[47:0]),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_granted_address(out_if.data[121:74]), .out_status(out_if.data[73:71]),
    .out_segments_in_use(out_if.data[70:64]), .out_grant_total(out_if.data[63:32]),
    .out_release_total(out_if.data[31:0]),
    .scan_seg, .scan_next, .scan_idx, .ctl
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    ffa_cell u_cell (
      .clk,
      .my_idx(ffa_pkg::IdxW'(g)),
      .ctl,
      .lower(segs[(g == 0) ? 0 : g - 1]),
      .upper(segs[(g == N - 1) ? N - 1 : g + 1]),
      .seg(segs[g])
    );
  end
endmodule
`default_nettype wire

### src/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One table entry; takes its neighbors' entries on shifts.
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_cell (
  input  wire logic                     clk,
  input  wire logic [ffa_pkg::IdxW-1:0] my_idx,
  input  wire ffa_pkg::cell_ctl_t       ctl,
  input  wire ffa_pkg::seg_t            lower,
  input  wire ffa_pkg::seg_t            upper,
  output ffa_pkg::seg_t                 seg
);
  ffa_pkg::seg_t seg_r, seg_nxt;
  logic [ffa_pkg::IdxW:0] me, tg;

  assign me = {1'b0, my_idx};
  assign tg = {1'b0, ctl.target};

  always_comb begin
    seg_nxt = seg_r;
    case (ctl.op)
      ffa_pkg::OP_INIT: begin
        if (me == '0) begin
          seg_nxt.offset  = '0;
          seg_nxt.length  = ctl.init_len;
          seg_nxt.is_free = 1'b1;
        end
      end
      ffa_pkg::OP_SPLIT: begin
        if (me == tg) begin
          seg_nxt.length  = ctl.need;
          seg_nxt.is_free = 1'b0;
        end else if (me == tg + 1'b1) begin
          seg_nxt.offset  = lower.offset + ctl.need;
          seg_nxt.length  = lower.length - ctl.need;
          seg_nxt.is_free = 1'b1;
        end else if (me > tg + 1'b1) begin
          seg_nxt = lower;
        end
      end
      ffa_pkg::OP_MARK: if (me == tg) seg_nxt.is_free = 1'b0;
      ffa_pkg::OP_FREE: if (me == tg) seg_nxt.is_free = 1'b1;
      ffa_pkg::OP_MERGE: begin
        if (me == tg) begin
          seg_nxt.length = seg_r.length + upper.length;
        end else if (me > tg) begin
          seg_nxt = upper;
        end
      end
      default: seg_nxt = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign seg = seg_r;
endmodule
`default_nettype wire

### src/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: scans the cell row one entry a cycle and issues cell operations.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ffa_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [47:0]                   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_action,
  input  wire logic [31:0]                   in_request_bytes,
  input  wire logic [47:0]                   in_release_address,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [47:0]                        out_granted_address,
  output logic [2:0]                         out_status,
  output logic [6:0]                         out_segments_in_use,
  output logic [31:0]                        out_grant_total,
  output logic [31:0]                        out_release_total,
  input  wire ffa_pkg::seg_t                 scan_seg,
  input  wire ffa_pkg::seg_t                 scan_next,
  output logic [ffa_pkg::IdxW-1:0]           scan_idx,
  output ffa_pkg::cell_ctl_t                 ctl
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam int OB = ffa_pkg::OffsetBits;

  logic [2:0]  state_r, state_nxt;
  logic [47:0] base_cfg_r, base_r;
  logic [31:0] region_cfg_r;
  logic [OB-1:0] region_r;
  logic [ffa_pkg::CntW-1:0] total_r, total_nxt, idx_r, idx_nxt;
  logic [31:0] grants_r, grants_nxt, rels_r, rels_nxt;
  logic        ready_r, ready_nxt;
  logic [OB-1:0] need_r, need_nxt, off_r, off_nxt;
  logic [47:0] gaddr_r, gaddr_nxt;
  logic [2:0]  stat_r, stat_nxt;
  ffa_pkg::cell_ctl_t ctl_c;

  logic [33:0] need_sum;
  logic [47:0] rel_off;
  logic [OB:0] need_min2;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign scan_idx = idx_r[ffa_pkg::IdxW-1:0];
  assign need_sum = {2'b0, in_request_bytes} + 34'(ffa_pkg::HeaderBytes + 7);
  assign rel_off  = in_release_address - 48'(ffa_pkg::HeaderBytes) - base_r;
  assign need_min2 = {1'b0, need_r} + (OB+1)'(ffa_pkg::MinSegment);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r   <= '0;
      region_cfg_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ffa_pkg::CFG_BASE) base_cfg_r <= cfg_data;
      else region_cfg_r <= cfg_data[31:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    grants_nxt = grants_r;
    rels_nxt   = rels_r;
    ready_nxt  = ready_r;
    need_nxt   = need_r;
    off_nxt    = off_r;
    gaddr_nxt  = gaddr_r;
    stat_nxt   = stat_r;
    ctl_c.op       = ffa_pkg::OP_HOLD;
    ctl_c.target   = idx_r[ffa_pkg::IdxW-1:0];
    ctl_c.need     = need_r;
    ctl_c.init_len = region_cfg_r[OB-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          gaddr_nxt = '0;
          idx_nxt   = '0;
          state_nxt = S_OUT;
          case (in_action)
            ffa_pkg::ACT_INIT: begin
              ctl_c.op   = ffa_pkg::OP_INIT;
              total_nxt  = ffa_pkg::CntW'(1);
              grants_nxt = '0;
              rels_nxt   = '0;
              ready_nxt  = 1'b1;
              stat_nxt   = ffa_pkg::ST_OK;
            end
            ffa_pkg::ACT_ALLOC: begin
              if (!ready_r) stat_nxt = ffa_pkg::ST_UNINIT;
              else if (in_request_bytes == '0) stat_nxt = ffa_pkg::ST_ZERO;
              // A rounded size past 32 bits is longer than any segment.
              else if (need_sum[33:32] != 2'b00) stat_nxt = ffa_pkg::ST_OOM;
              else begin
                need_nxt = OB'({need_sum[33:3], 3'b000});
                if (need_sum[33:3] < 31'(ffa_pkg::MinSegment / 8))
                  need_nxt = OB'(ffa_pkg::MinSegment);
                state_nxt = S_ALLOC;
              end
            end
            ffa_pkg::ACT_RELEASE: begin
              if (in_release_address == '0) stat_nxt = ffa_pkg::ST_NULL;
              else if (!ready_r) stat_nxt = ffa_pkg::ST_UNINIT;
              else if (rel_off >= 48'(region_r)) stat_nxt = ffa_pkg::ST_INVALID;
              else begin
                off_nxt   = rel_off[OB-1:0];
                state_nxt = S_FIND;
              end
            end
            default: stat_nxt = ffa_pkg::ST_INVALID;
          endcase
        end
      end
      S_ALLOC: begin
        if (idx_r >= total_r) begin
          stat_nxt  = ffa_pkg::ST_OOM;
          state_nxt = S_OUT;
        end else if (scan_seg.is_free && scan_seg.length >= need_r) begin
          if ({1'b0, scan_seg.length} >= need_min2 &&
              total_r < ffa_pkg::CntW'(ffa_pkg::MaxSegments)) begin
            ctl_c.op  = ffa_pkg::OP_SPLIT;
            total_nxt = total_r + 1'b1;
          end else begin
            ctl_c.op = ffa_pkg::OP_MARK;
          end
          grants_nxt = grants_r + 1'b1;
          gaddr_nxt  = base_r + 48'(scan_seg.offset) + 48'(ffa_pkg::HeaderBytes);
          stat_nxt   = ffa_pkg::ST_OK;
          state_nxt  = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FIND: begin
        if (idx_r >= total_r) begin
          stat_nxt  = ffa_pkg::ST_INVALID;
          state_nxt = S_OUT;
        end else if (scan_seg.offset == off_r) begin
          if (scan_seg.is_free) begin
            stat_nxt  = ffa_pkg::ST_DOUBLE;
            state_nxt = S_OUT;
          end else begin
            ctl_c.op  = ffa_pkg::OP_FREE;
            rels_nxt  = rels_r + 1'b1;
            stat_nxt  = ffa_pkg::ST_OK;
            idx_nxt   = '0;
            state_nxt = S_MERGE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MERGE: begin
        // Walks the row from entry zero; after a merge the same entry is
        // checked again against its new upper neighbor.
        if (idx_r + 1'b1 >= total_r) begin
          state_nxt = S_OUT;
        end else if (scan_seg.is_free && scan_next.is_free) begin
          ctl_c.op  = ffa_pkg::OP_MERGE;
          total_nxt = total_r - 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= '0;
      idx_r    <= '0;
      grants_r <= '0;
      rels_r   <= '0;
      ready_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      idx_r    <= idx_nxt;
      grants_r <= grants_nxt;
      rels_r   <= rels_nxt;
      ready_r  <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r  <= need_nxt;
    off_r   <= off_nxt;
    gaddr_r <= gaddr_nxt;
    stat_r  <= stat_nxt;
    if (accept && in_action == ffa_pkg::ACT_INIT) begin
      base_r   <= base_cfg_r;
      region_r <= region_cfg_r[OB-1:0];
    end
  end

  assign ctl                 = ctl_c;
  assign out_valid           = (state_r == S_OUT);
  assign out_granted_address = gaddr_r;
  assign out_status          = stat_r;
  assign out_segments_in_use = 7'(total_r);
  assign out_grant_total     = grants_r;
  assign out_release_total   = rels_r;

  `FFA_ASSERT(a_total_range, clk, rst_n, total_r <= ffa_pkg::CntW'(ffa_pkg::MaxSegments), "segment count over table size")
  `FFA_ASSERT(a_ready_idle, clk, rst_n, in_ready == (state_r == S_IDLE), "ready outside idle")
  `FFA_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid && $stable(out_status), "result dropped while stalled")
endmodule
`default_nettype wire
